// ===== src/fixed_block_pool_allocator_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the fixed block pool allocator
// Immediate-consequence and next-cycle checks, clocked on clk, off in reset.
// ----------------------------------------------------------------------------
`ifndef FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`define FIXED_BLOCK_POOL_ALLOCATOR_CORE_MACROS_SVH
`ifndef NO_ASSERTIONS
`define FLP_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`define FLP_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define FLP_ASSERT_NOW(label, ante, cons, msg)
`define FLP_ASSERT_NEXT(label, ante, cons, msg)
`endif
`endif

// ===== src/flp_pkg.sv =====
// ----------------------------------------------------------------------------
// flp_pkg
// Shared types and codes of the fixed block pool allocator.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package flp_pkg;

  typedef enum logic {
    REQ_ALLOC = 1'b0,
    REQ_FREE  = 1'b1
  } req_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_ZERO  = 2'd2,
    ST_RANGE = 2'd3
  } status_t;

  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_IDX_W-1:0] CFG_NUM_BLOCKS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_OBJECT_SIZE = 1'b1;

  localparam logic [8:0]  NUM_BLOCKS_RST  = 9'd256;
  localparam logic [15:0] OBJECT_SIZE_RST = 16'd16;

  typedef struct packed {
    req_t        req_type;
    logic [15:0] request_bytes;
    logic [7:0]  block_index;
  } in_item_t;

  typedef struct packed {
    logic        ok;
    logic [7:0]  granted_block;
    status_t     status;
    logic [31:0] used_bytes;
    logic [8:0]  live_count;
  } out_item_t;

endpackage

// ===== src/fixed_block_pool_allocator_core.sv =====
// ----------------------------------------------------------------------------
// fixed_block_pool_allocator_core
// Fixed-size block pool with a LIFO free list, used-byte and live counters.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid / in_stall / in_data carries one request item
//   (allocate or free). Output channel out_valid / out_stall / out_data
//   returns exactly one result item per request, in order.
//   Config port cfg_we / cfg_index / cfg_wdata writes num_blocks (index 0)
//   and object_size (index 1); write only while the block is idle.
//   Processing: on acceptance the item is registered and the link of the
//   freed-stack head is read from the link memory; then the update is
//   applied and the result register loaded. No new item is accepted until
//   the held item has been processed.
//   An item may be accepted while the previous result waits on out_stall;
//   it is then held until the result register frees up.
//   Reset (rst_n low, synchronous): pool holds blocks 0..N-1 ascending,
//   totals cleared, num_blocks = 256, object_size = 16. No clearing pass.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "fixed_block_pool_allocator_core_macros.svh"

module fixed_block_pool_allocator_core import flp_pkg::*; #(
  parameter int POOL_DEPTH = 256
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int IDX_W = $clog2(POOL_DEPTH);
  localparam int PTR_W = IDX_W + 1;

  logic [8:0]  num_blocks_r;
  logic [15:0] object_size_r;

  in_item_t  item_r;
  logic      busy_r;
  logic      out_valid_r;
  out_item_t out_data_r;

  logic             in_accept;
  logic             step;
  out_item_t        result;
  logic [PTR_W-1:0] head_ptr;
  logic             head_live;
  logic [PTR_W-1:0] link_rdata;
  logic             wr_en;
  logic [IDX_W-1:0] wr_addr;
  logic [PTR_W-1:0] wr_data;

  assign in_stall  = busy_r;
  assign in_accept = in_valid && !busy_r;
  assign step      = busy_r && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_blocks_r  <= NUM_BLOCKS_RST;
      object_size_r <= OBJECT_SIZE_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_BLOCKS:  num_blocks_r  <= cfg_wdata[8:0];
        CFG_OBJECT_SIZE: object_size_r <= cfg_wdata[15:0];
        default: begin
          num_blocks_r <= num_blocks_r;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        busy_r <= 1'b1;
      end else if (step) begin
        busy_r <= 1'b0;
      end
      if (step) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      item_r <= in_data;
    end
    if (step) begin
      out_data_r <= result;
    end
  end

  flp_link_mem #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_link_mem (
    .clk     (clk),
    .rd_en   (in_accept && head_live),
    .rd_addr (head_ptr[IDX_W-1:0]),
    .rd_data (link_rdata),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  flp_alloc_ctl #(
    .POOL_DEPTH (POOL_DEPTH)
  ) u_alloc_ctl (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .item        (item_r),
    .link_rdata  (link_rdata),
    .num_blocks  (num_blocks_r),
    .object_size (object_size_r),
    .result      (result),
    .head_ptr    (head_ptr),
    .head_live   (head_live),
    .wr_en       (wr_en),
    .wr_addr     (wr_addr),
    .wr_data     (wr_data)
  );

  `FLP_ASSERT_NEXT(a_accept_busy, in_accept, busy_r, "accepted item not held for processing")
  `FLP_ASSERT_NEXT(a_step_result, step, out_valid_r && !busy_r, "processed item gave no result")
  `FLP_ASSERT_NOW(a_ok_status, out_valid_r, out_data_r.ok == (out_data_r.status == ST_OK),
    "ok flag disagrees with status")
  `FLP_ASSERT_NOW(a_grant_zero, out_valid_r && !out_data_r.ok,
    out_data_r.granted_block == 8'd0, "failed request carries a block index")

endmodule

// ===== src/flp_link_mem.sv =====
// ----------------------------------------------------------------------------
// flp_link_mem
// Link store of the freed-block stack: one write port, one registered read.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flp_link_mem #(
  parameter int POOL_DEPTH = 256,
  localparam int IDX_W = $clog2(POOL_DEPTH),
  localparam int PTR_W = IDX_W + 1
) (
  input  logic             clk,
  input  logic             rd_en,
  input  logic [IDX_W-1:0] rd_addr,
  output logic [PTR_W-1:0] rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  logic [PTR_W-1:0] wr_data
);

  logic [PTR_W-1:0] mem [POOL_DEPTH];
  logic [PTR_W-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
    end
  end

  assign rd_data = rd_data_r;

endmodule

// ===== src/flp_alloc_ctl.sv =====
// ----------------------------------------------------------------------------
// flp_alloc_ctl
// Pool state and the allocate / free update for one item.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module flp_alloc_ctl import flp_pkg::*; #(
  parameter int POOL_DEPTH = 256,
  localparam int IDX_W = $clog2(POOL_DEPTH),
  localparam int PTR_W = IDX_W + 1
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  in_item_t         item,
  input  logic [PTR_W-1:0] link_rdata,
  input  logic [8:0]       num_blocks,
  input  logic [15:0]      object_size,
  output out_item_t        result,
  output logic [PTR_W-1:0] head_ptr,
  output logic             head_live,
  output logic             wr_en,
  output logic [IDX_W-1:0] wr_addr,
  output logic [PTR_W-1:0] wr_data
);

  localparam int CW = (PTR_W > 9) ? PTR_W : 9;
  localparam logic [CW-1:0] DEPTH_C = CW'(POOL_DEPTH);

  logic [PTR_W-1:0] freed_head_r, freed_head_nxt;
  logic [PTR_W-1:0] fresh_mark_r, fresh_mark_nxt;
  logic [31:0]      byte_total_r, byte_total_nxt;
  logic [8:0]       alloc_count_r, alloc_count_nxt;

  logic [CW-1:0] nb_x, eff, head_x, fresh_x, idx_x, granted_x;
  logic [32:0]   sum_w;
  logic          free_ok;

  assign nb_x      = CW'(num_blocks);
  assign eff       = (nb_x > DEPTH_C) ? DEPTH_C : nb_x;
  assign head_x    = CW'(freed_head_r);
  assign fresh_x   = CW'(fresh_mark_r);
  assign idx_x     = CW'(item.block_index);
  assign head_live = head_x < DEPTH_C;
  assign sum_w     = {1'b0, byte_total_r} + {17'd0, item.request_bytes};

  always_comb begin
    freed_head_nxt  = freed_head_r;
    fresh_mark_nxt  = fresh_mark_r;
    byte_total_nxt  = byte_total_r;
    alloc_count_nxt = alloc_count_r;
    granted_x       = '0;
    free_ok         = 1'b0;
    result.ok       = 1'b0;
    result.status   = ST_OK;
    case (item.req_type)
      REQ_ALLOC: begin
        if (item.request_bytes == 16'd0) begin
          result.status = ST_ZERO;
        end else if (head_live) begin
          granted_x      = head_x;
          freed_head_nxt = link_rdata;
          result.ok      = 1'b1;
        end else if (fresh_x < eff) begin
          granted_x      = fresh_x;
          fresh_mark_nxt = fresh_mark_r + PTR_W'(1);
          result.ok      = 1'b1;
        end else begin
          result.status = ST_EMPTY;
        end
        if (result.ok) begin
          byte_total_nxt = sum_w[32] ? 32'hFFFF_FFFF : sum_w[31:0];
          if (alloc_count_r != 9'h1FF) begin
            alloc_count_nxt = alloc_count_r + 9'd1;
          end
        end
      end
      REQ_FREE: begin
        if (idx_x >= eff) begin
          result.status = ST_RANGE;
        end else begin
          free_ok        = 1'b1;
          freed_head_nxt = idx_x[PTR_W-1:0];
          byte_total_nxt = (byte_total_r > {16'd0, object_size}) ?
                           byte_total_r - {16'd0, object_size} : 32'd0;
          if (alloc_count_r != 9'd0) begin
            alloc_count_nxt = alloc_count_r - 9'd1;
          end
          result.ok = 1'b1;
        end
      end
      default: begin
        result.status = ST_OK;
      end
    endcase
    result.granted_block = granted_x[7:0];
    result.used_bytes    = byte_total_nxt;
    result.live_count    = alloc_count_nxt;
  end

  assign wr_en    = step && free_ok;
  assign wr_addr  = idx_x[IDX_W-1:0];
  assign wr_data  = freed_head_r;
  assign head_ptr = freed_head_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freed_head_r  <= PTR_W'(POOL_DEPTH);
      fresh_mark_r  <= '0;
      byte_total_r  <= '0;
      alloc_count_r <= '0;
    end else if (step) begin
      freed_head_r  <= freed_head_nxt;
      fresh_mark_r  <= fresh_mark_nxt;
      byte_total_r  <= byte_total_nxt;
      alloc_count_r <= alloc_count_nxt;
    end
  end

endmodule
